// ===== rtl/rcbp_pkg.sv =====
`default_nettype none

package rcbp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 15;
  localparam int ST_W      = 26;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam int DIFF_W = SAMPLE_W + 1 + FRAC_BITS;
  localparam int OPND_W = ((DIFF_W > ST_W) ? DIFF_W : ST_W) + 1;
  localparam int PROD_W = OPND_W + COEF_W + 1;
  localparam int TRNC_W = PROD_W - COEF_W;
  localparam int SAT_W  = ((TRNC_W > ST_W) ? TRNC_W : ST_W) + 1;

  localparam logic [COEF_W-1:0] HP_COEFF_RESET = COEF_W'(29315);
  localparam logic [COEF_W-1:0] LP_COEFF_RESET = COEF_W'(18737);

  localparam logic [CFG_IDX_W-1:0] REG_HP_COEFF = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LP_COEFF = CFG_IDX_W'(1);

  localparam logic signed [SAT_W-1:0] ST_HI = SAT_W'((64'sd1 <<< (ST_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] ST_LO = SAT_W'(-(64'sd1 <<< (ST_W - 1)));
  localparam logic signed [ST_W-1:0]  OUT_HI = ST_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [ST_W-1:0]  OUT_LO = ST_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

  localparam logic [PROD_W-1:0] COEF_BIAS = PROD_W'((64'd1 << COEF_W) - 64'd1);
  localparam logic [ST_W-1:0]   FRAC_BIAS = ST_W'((64'd1 << FRAC_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HP,
    ST_UPD_HP,
    ST_MUL_LP,
    ST_UPD_LP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_hp;
    logic upd_hp;
    logic mul_lp;
    logic upd_lp;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SAT_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > ST_HI) begin
      r = ST_HI[ST_W-1:0];
    end else if (v < ST_LO) begin
      r = ST_LO[ST_W-1:0];
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [TRNC_W-1:0] trunc_coef(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (p[PROD_W-1] ? $signed(COEF_BIAS) : $signed(PROD_W'(0)));
    return t[PROD_W-1:COEF_W];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] to_sample(input logic signed [ST_W-1:0] v);
    logic signed [ST_W-1:0] t;
    logic signed [ST_W-1:0] q;
    logic signed [SAMPLE_W-1:0] r;
    t = v + (v[ST_W-1] ? $signed(FRAC_BIAS) : $signed(ST_W'(0)));
    q = t >>> FRAC_BITS;
    if (q > OUT_HI) begin
      r = OUT_HI[SAMPLE_W-1:0];
    end else if (q < OUT_LO) begin
      r = OUT_LO[SAMPLE_W-1:0];
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rcbp_ctrl.sv =====
`default_nettype none

module rcbp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rcbp_pkg::status_t status,
  output rcbp_pkg::cmd_t        cmd
);
  import rcbp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL_HP;
        end
      end
      ST_MUL_HP: begin
        cmd.mul_hp = 1'b1;
        state_next = ST_UPD_HP;
      end
      ST_UPD_HP: begin
        cmd.upd_hp = 1'b1;
        state_next = ST_MUL_LP;
      end
      ST_MUL_LP: begin
        cmd.mul_lp = 1'b1;
        state_next = ST_UPD_LP;
      end
      ST_UPD_LP: begin
        cmd.upd_lp = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MUL_HP))
    else $error("transfer did not start the high-pass multiply");
  a_lp_to_out: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_lp |=> (state == ST_OUT))
    else $error("low-pass update not followed by output");

endmodule

`default_nettype wire

// ===== rtl/rcbp_dpath.sv =====
`default_nettype none

module rcbp_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire rcbp_pkg::cmd_t                       cmd,
  output rcbp_pkg::status_t                         status,
  input  wire logic signed [rcbp_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [rcbp_pkg::SAMPLE_W-1:0]      sample_out,
  input  wire logic                                 cfg_valid,
  input  wire logic [rcbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rcbp_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import rcbp_pkg::*;

  logic [COEF_W-1:0]        hp_coeff;
  logic [COEF_W-1:0]        lp_coeff;
  logic signed [SAMPLE_W-1:0] prev_in;
  logic signed [ST_W-1:0]   hp;
  logic signed [ST_W-1:0]   lp;
  logic signed [OPND_W-1:0] opnd;
  logic signed [PROD_W-1:0] prod;

  logic signed [DIFF_W-1:0] diff;
  logic signed [OPND_W-1:0] sum_next;
  logic signed [COEF_W:0]   mul_coef;
  logic signed [TRNC_W-1:0] prod_trunc;
  logic signed [ST_W-1:0]   hp_next;
  logic signed [ST_W-1:0]   lp_next;

  always_comb begin
    diff       = (DIFF_W'(sample_in) - DIFF_W'(prev_in)) <<< FRAC_BITS;
    sum_next   = OPND_W'(hp) + OPND_W'(diff);
    mul_coef   = $signed({1'b0, (cmd.mul_hp ? hp_coeff : lp_coeff)});
    prod_trunc = trunc_coef(prod);
    hp_next    = sat_st(SAT_W'(prod_trunc));
    lp_next    = sat_st(SAT_W'(lp) + SAT_W'(prod_trunc));
    status.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_coeff <= HP_COEFF_RESET;
      lp_coeff <= LP_COEFF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HP_COEFF: hp_coeff <= cfg_data[COEF_W-1:0];
        REG_LP_COEFF: lp_coeff <= cfg_data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_in <= '0;
      hp      <= '0;
      lp      <= '0;
    end else begin
      if (cmd.load) begin
        prev_in <= sample_in;
      end
      if (cmd.upd_hp) begin
        hp <= hp_next;
      end
      if (cmd.upd_lp) begin
        lp <= lp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd <= sum_next;
    end else if (cmd.upd_hp) begin
      opnd <= OPND_W'(hp_next) - OPND_W'(lp);
    end
    if (cmd.mul_hp || cmd.mul_lp) begin
      prod <= PROD_W'(mul_coef) * PROD_W'(opnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_out <= to_sample(lp);
    end
  end

  a_out_set: assert property (@(posedge clk) disable iff (rst) cmd.load_out |=> out_valid)
    else $error("output register not marked valid");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_out && out_valid && !out_ready))
    else $error("pending result overwritten");
  a_lp_hold: assert property (@(posedge clk) disable iff (rst)
    (!cmd.upd_lp && !$past(rst)) |=> $stable(lp))
    else $error("low-pass state changed outside its update");

endmodule

`default_nettype wire

// ===== rtl/rc_bandpass_audio_filter.sv =====
`default_nettype none

// First-order RC band-pass for signed 16-bit audio: an RC high-pass
// y = a*(y_prev + x - x_prev) followed by an RC low-pass y = y_prev + b*(x - y_prev),
// with 26-bit states carrying 8 fraction bits, saturating states, and an output
// truncated toward zero and clamped to 16 bits. Coefficients a (register 0) and b
// (register 1) are unsigned Q0.15 and reset to 300 Hz and 3400 Hz at 16 kHz; write
// them only while the filter is idle. For each item the two dependent multiplies share
// one multiplier, each followed by a truncate-and-saturate step, and a final output
// step loads the output register, waiting while it still holds an untaken result. A new
// sample is taken once the previous one has reached the output register, which holds
// it until it is taken.
module rc_bandpass_audio_filter (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [rcbp_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [rcbp_pkg::SAMPLE_W-1:0]      sample_out,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rcbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rcbp_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import rcbp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  rcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rcbp_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

`default_nettype wire
